[design/mar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_pkg: shared types and constants of the MIDI arp event router
// Beat layouts, config struct, sequencer states and MIDI codes.
// ----------------------------------------------------------------------------
package mar_pkg;

    // midi status fields and message types
    localparam logic [7:0] MIDI_TYPE_MASK = 8'hf0;
    localparam logic [7:0] MIDI_CHAN_MASK = 8'h0f;
    localparam logic [7:0] MIDI_NOTE_ON   = 8'h90;
    localparam logic [7:0] MIDI_NOTE_OFF  = 8'h80;
    localparam logic [7:0] MIDI_CC        = 8'hb0;

    // operation codes of an input beat
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // result kinds
    localparam logic KIND_EXT = 1'b0;
    localparam logic KIND_INT = 1'b1;

    // arp modes
    localparam logic [1:0] ARP_INTERNAL = 2'd0;
    localparam logic [1:0] ARP_EXTERNAL = 2'd2;

    // config register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] REG_ARP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_NUM = 2'd2;

    // most results one flush may produce
    localparam int MAX_RESULTS = 32;

    typedef struct packed {
        logic [1:0] arp_mode;
        logic       morph_en;
        logic [6:0] morph_num;
    } t_cfg;

    typedef struct packed {
        logic        operation;
        logic        from_arp;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [15:0] block_offset;
        logic [3:0]  flush_channel;
        logic [1:0]  flush_bank;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [15:0] offset;
        logic        play;
        logic        captured;
        logic [6:0]  mval;
        logic        last;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_INT,
        ST_FLUSH
    } t_state;

endpackage

[design/midi_arp_event_router.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_arp_event_router: MIDI event router with held-note bitmaps
//
// Input channel: a beat is taken at a clock edge with start high and busy
// low. Operation route sends one MIDI event through the arp routing or the
// morph controller check; operation flush releases the held external notes
// of one channel and bank of FLUSH_BANK_SIZE notes.
// Results: each result beat stands on the o_ ports for one cycle with
// o_strobe high; o_last marks the final beat of an item. The receiver cannot
// stall. A flush with nothing held gives no beat at all.
// An event's bitmap rows are read at the accepting edge and its first result
// is registered from them in the evaluate state; a flush's first note-off
// comes from the bank scan state, after the empty bank bits below the lowest
// held note. A new beat is taken only once the item is done, which covers
// the row read-modify-write of the bitmap memories and, on a flush, the
// bit-serial scan of up to FLUSH_BANK_SIZE bank bits; the scan stops at the
// last held note or at the MAX_RESULTS-th note-off.
// Reset: config returns to defaults, then a clearing pass over all
// CHANNELS * ceil(NOTES / FLUSH_BANK_SIZE) rows (64 by default) zeroes
// both bitmaps with busy high. Config writes are taken at any time.
// ----------------------------------------------------------------------------
module midi_arp_event_router
    import mar_pkg::*;
#(
    parameter int CHANNELS        = 16,
    parameter int NOTES           = 128,
    parameter int FLUSH_BANK_SIZE = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_operation,
    input  logic                  i_from_arp,
    input  logic [7:0]            i_status,
    input  logic [6:0]            i_data1,
    input  logic [6:0]            i_data2,
    input  logic [15:0]           i_block_offset,
    input  logic [3:0]            i_flush_channel,
    input  logic [1:0]            i_flush_bank,
    output logic                  o_strobe,
    output logic                  o_result_kind,
    output logic [7:0]            o_out_status,
    output logic [6:0]            o_out_data1,
    output logic [6:0]            o_out_data2,
    output logic [15:0]           o_out_offset,
    output logic                  o_play_internal,
    output logic                  o_morph_captured,
    output logic [6:0]            o_morph_value,
    output logic                  o_last
);

    localparam int BANKS = (NOTES + FLUSH_BANK_SIZE - 1) / FLUSH_BANK_SIZE;
    localparam int ROWS  = CHANNELS * BANKS;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    t_cfg                       r_cfg;
    t_item                      w_item;
    t_result                    w_res;
    logic                       w_res_vld;
    logic                       w_rd_en;
    logic [ROW_W-1:0]           w_rd_addr;
    logic [ROW_W-1:0]           w_wr_addr;
    logic [FLUSH_BANK_SIZE-1:0] w_ext_rdata;
    logic [FLUSH_BANK_SIZE-1:0] w_int_rdata;
    logic                       w_ext_we;
    logic                       w_int_we;
    logic [FLUSH_BANK_SIZE-1:0] w_ext_wdata;
    logic [FLUSH_BANK_SIZE-1:0] w_int_wdata;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.arp_mode  <= ARP_INTERNAL;
            r_cfg.morph_en  <= 1'b0;
            r_cfg.morph_num <= 7'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ARP_MODE:  r_cfg.arp_mode  <= i_cfg_wdata[1:0];
                REG_MORPH_EN:  r_cfg.morph_en  <= i_cfg_wdata[0];
                REG_MORPH_NUM: r_cfg.morph_num <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input beat
    assign w_item.operation     = i_operation;
    assign w_item.from_arp      = i_from_arp;
    assign w_item.status        = i_status;
    assign w_item.data1         = i_data1;
    assign w_item.data2         = i_data2;
    assign w_item.block_offset  = i_block_offset;
    assign w_item.flush_channel = i_flush_channel;
    assign w_item.flush_bank    = i_flush_bank;

    mar_seq #(
        .CHANNELS        (CHANNELS),
        .NOTES           (NOTES),
        .FLUSH_BANK_SIZE (FLUSH_BANK_SIZE),
        .ROW_W           (ROW_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (w_item),
        .i_cfg       (r_cfg),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_ext_rdata (w_ext_rdata),
        .i_int_rdata (w_int_rdata),
        .o_wr_addr   (w_wr_addr),
        .o_ext_we    (w_ext_we),
        .o_ext_wdata (w_ext_wdata),
        .o_int_we    (w_int_we),
        .o_int_wdata (w_int_wdata),
        .o_res       (w_res),
        .o_res_vld   (w_res_vld)
    );

    // external held-note bitmap
    mar_held_mem #(
        .ROWS   (ROWS),
        .WIDTH  (FLUSH_BANK_SIZE),
        .ADDR_W (ROW_W)
    ) u_ext_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_ext_rdata),
        .i_wr_en   (w_ext_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_ext_wdata)
    );

    // internal held-note bitmap
    mar_held_mem #(
        .ROWS   (ROWS),
        .WIDTH  (FLUSH_BANK_SIZE),
        .ADDR_W (ROW_W)
    ) u_int_mem (
        .i_clk     (i_clk),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_int_rdata),
        .i_wr_en   (w_int_we),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_int_wdata)
    );

    // result ports
    assign o_strobe         = w_res_vld;
    assign o_result_kind    = w_res.kind;
    assign o_out_status     = w_res.status;
    assign o_out_data1      = w_res.data1;
    assign o_out_data2      = w_res.data2;
    assign o_out_offset     = w_res.offset;
    assign o_play_internal  = w_res.play;
    assign o_morph_captured = w_res.captured;
    assign o_morph_value    = w_res.mval;
    assign o_last           = w_res.last;

    // an accepted beat keeps the block busy for at least the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("block not busy after accept");

    // an internal decision always closes its item
    a_int_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_result_kind == KIND_INT) |-> o_last)
        else $error("internal result without last");

    // a swallowed morph controller is never played
    a_morph_noplay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_morph_captured |-> !o_play_internal && (o_result_kind == KIND_INT))
        else $error("captured morph event marked for play");

    // more results pending means the block cannot take a new item
    a_more_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("idle while an item still has results");

endmodule

[design/mar_held_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_held_mem: held-note bitmap memory
// One row per channel and note bank, one read and one write port,
// registered read data.
// ----------------------------------------------------------------------------
module mar_held_mem #(
    parameter int ROWS   = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data
);

    logic [WIDTH-1:0] r_mem [ROWS];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/mar_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mar_seq: routing sequencer
// Reads both bitmap rows at accept, decides the route, writes rows back and
// scans a bank bit by bit on flush. Drives the result register.
// ----------------------------------------------------------------------------
module mar_seq
    import mar_pkg::*;
#(
    parameter int CHANNELS        = 16,
    parameter int NOTES           = 128,
    parameter int FLUSH_BANK_SIZE = 32,
    parameter int ROW_W           = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  t_item                      i_item,
    input  t_cfg                       i_cfg,
    output logic                       o_rd_en,
    output logic [ROW_W-1:0]           o_rd_addr,
    input  logic [FLUSH_BANK_SIZE-1:0] i_ext_rdata,
    input  logic [FLUSH_BANK_SIZE-1:0] i_int_rdata,
    output logic [ROW_W-1:0]           o_wr_addr,
    output logic                       o_ext_we,
    output logic [FLUSH_BANK_SIZE-1:0] o_ext_wdata,
    output logic                       o_int_we,
    output logic [FLUSH_BANK_SIZE-1:0] o_int_wdata,
    output t_result                    o_res,
    output logic                       o_res_vld
);

    localparam int BANKS  = (NOTES + FLUSH_BANK_SIZE - 1) / FLUSH_BANK_SIZE;
    localparam int ROWS   = CHANNELS * BANKS;
    localparam int WORD_W = FLUSH_BANK_SIZE;
    localparam int BIT_W  = (FLUSH_BANK_SIZE > 1) ? $clog2(FLUSH_BANK_SIZE) : 1;
    localparam int CALC_W = 12;
    localparam int ENT_W  = 14;
    localparam int CNT_W  = $clog2(MAX_RESULTS);

    // note -> {bank, position in bank}, built by counting at elaboration
    function automatic logic [128*ENT_W-1:0] f_note_tab();
        logic [128*ENT_W-1:0] tab;
        logic [6:0]           q;
        logic [6:0]           r;
        tab = '0;
        q   = '0;
        r   = '0;
        for (int n = 0; n < 128; n++) begin
            tab[n*ENT_W +: ENT_W] = {q, r};
            if (r == 7'(FLUSH_BANK_SIZE - 1)) begin
                r = '0;
                q = q + 7'd1;
            end else begin
                r = r + 7'd1;
            end
        end
        return tab;
    endfunction

    localparam logic [128*ENT_W-1:0] NOTE_TAB = f_note_tab();

    t_state              r_state, n_state;
    logic [ROW_W-1:0]    r_clr;
    t_item               r_item;
    logic [ROW_W-1:0]    r_row;
    logic [BIT_W-1:0]    r_pos;
    logic                r_ok;
    logic                r_play;
    logic [WORD_W-1:0]   r_word;
    logic [BIT_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_cnt;
    t_result             r_res, n_res;
    logic                r_res_vld, n_res_vld;

    logic                w_accept;
    logic [7:0]          w_ch8;
    logic [3:0]          w_ch;
    logic [ENT_W-1:0]    w_ent;
    logic [CALC_W-1:0]   w_ev_row;
    logic [CALC_W-1:0]   w_fl_row;
    logic                w_ev_ok;
    logic                w_fl_ok;
    logic [CALC_W-1:0]   w_row;
    logic                w_ok;

    logic [7:0]          w_type;
    logic                w_is_on;
    logic                w_is_off;
    logic                w_routed;
    logic                w_ext_bit;
    logic                w_int_bit;
    logic                w_ext_emit;
    logic                w_play;
    logic                w_morph;
    logic [WORD_W-1:0]   w_ext_upd;
    logic [WORD_W-1:0]   w_int_upd;

    logic                w_fl_bit;
    logic [WORD_W-1:0]   w_fl_clr;
    logic                w_fl_done;
    logic [7:0]          w_fl_note;

    // accept and row address of the incoming beat
    assign w_accept = i_start && (r_state == ST_IDLE);
    assign o_busy   = (r_state != ST_IDLE);
    assign w_ch8    = i_item.status & MIDI_CHAN_MASK;
    assign w_ch     = w_ch8[3:0];
    assign w_ent    = NOTE_TAB[int'(i_item.data1)*ENT_W +: ENT_W];
    assign w_ev_row = CALC_W'(w_ch) * CALC_W'(BANKS) + CALC_W'(w_ent[13:7]);
    assign w_fl_row = CALC_W'(i_item.flush_channel) * CALC_W'(BANKS)
                    + CALC_W'(i_item.flush_bank);
    assign w_ev_ok  = (5'(w_ch) < 5'(CHANNELS)) && (8'(i_item.data1) < 8'(NOTES));
    assign w_fl_ok  = (5'(i_item.flush_channel) < 5'(CHANNELS))
                   && (8'(i_item.flush_bank) < 8'(BANKS));
    assign w_row    = (i_item.operation == OP_FLUSH) ? w_fl_row : w_ev_row;
    assign w_ok     = (i_item.operation == OP_FLUSH) ? w_fl_ok : w_ev_ok;

    assign o_rd_en   = w_accept;
    assign o_rd_addr = w_row[ROW_W-1:0];

    // event classification on the held beat
    assign w_type     = r_item.status & MIDI_TYPE_MASK;
    assign w_is_on    = (w_type == MIDI_NOTE_ON) && (r_item.data2 != '0);
    assign w_is_off   = (w_type == MIDI_NOTE_OFF)
                     || ((w_type == MIDI_NOTE_ON) && (r_item.data2 == '0));
    assign w_routed   = r_item.from_arp && (i_cfg.arp_mode != ARP_INTERNAL);
    assign w_ext_bit  = r_ok && i_ext_rdata[r_pos];
    assign w_int_bit  = r_ok && i_int_rdata[r_pos];
    assign w_ext_emit = !w_is_off || w_ext_bit;
    assign w_morph    = i_cfg.morph_en && (w_type == MIDI_CC)
                     && (r_item.data1 == i_cfg.morph_num);

    // internal play decision
    always_comb begin
        if (i_cfg.arp_mode == ARP_EXTERNAL) begin
            priority if (w_is_on) begin
                w_play = 1'b0;
            end else if (w_is_off) begin
                w_play = w_int_bit;
            end else begin
                w_play = 1'b1;
            end
        end else begin
            w_play = 1'b1;
        end
    end

    // modified rows for note events
    always_comb begin
        w_ext_upd        = i_ext_rdata;
        w_ext_upd[r_pos] = w_is_on;
        w_int_upd        = i_int_rdata;
        w_int_upd[r_pos] = w_is_on;
    end

    // flush scan step
    assign w_fl_bit  = r_word[r_idx];
    assign w_fl_clr  = r_word & ~(WORD_W'(1) << r_idx);
    assign w_fl_done = (w_fl_clr == '0)
                    || (w_fl_bit && (r_cnt == CNT_W'(MAX_RESULTS - 1)))
                    || (r_idx == BIT_W'(WORD_W - 1));
    assign w_fl_note = 8'(r_item.flush_bank) * 8'(FLUSH_BANK_SIZE) + 8'(r_idx);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ROW_W'(ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_item.operation == OP_FLUSH) begin
                    n_state = (r_ok && (i_ext_rdata != '0)) ? ST_FLUSH : ST_IDLE;
                end else if (w_routed && w_ext_emit) begin
                    n_state = ST_INT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_INT: begin
                n_state = ST_IDLE;
            end
            ST_FLUSH: begin
                if (w_fl_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // memory writes and result beats
    always_comb begin
        n_res       = '0;
        n_res_vld   = 1'b0;
        o_wr_addr   = r_row;
        o_ext_we    = 1'b0;
        o_ext_wdata = w_ext_upd;
        o_int_we    = 1'b0;
        o_int_wdata = w_int_upd;
        unique case (r_state)
            ST_CLEAR: begin
                o_wr_addr   = r_clr;
                o_ext_we    = 1'b1;
                o_ext_wdata = '0;
                o_int_we    = 1'b1;
                o_int_wdata = '0;
            end
            ST_EVAL: begin
                if (r_item.operation == OP_ROUTE) begin
                    if (w_routed) begin
                        o_ext_we  = r_ok && (w_is_on || w_is_off);
                        o_int_we  = r_ok && w_play && (w_is_on || w_is_off);
                        n_res_vld = 1'b1;
                        if (w_ext_emit) begin
                            n_res.kind   = KIND_EXT;
                            n_res.status = r_item.status;
                            n_res.data1  = r_item.data1;
                            n_res.data2  = r_item.data2;
                            n_res.offset = r_item.block_offset;
                        end else begin
                            n_res.kind = KIND_INT;
                            n_res.play = w_play;
                            n_res.last = 1'b1;
                        end
                    end else begin
                        n_res_vld      = 1'b1;
                        n_res.kind     = KIND_INT;
                        n_res.play     = !w_morph;
                        n_res.captured = w_morph;
                        n_res.mval     = w_morph ? r_item.data2 : '0;
                        n_res.last     = 1'b1;
                    end
                end
            end
            ST_INT: begin
                n_res_vld  = 1'b1;
                n_res.kind = KIND_INT;
                n_res.play = r_play;
                n_res.last = 1'b1;
            end
            ST_FLUSH: begin
                o_ext_we    = w_fl_done;
                o_ext_wdata = w_fl_clr;
                if (w_fl_bit) begin
                    n_res_vld    = 1'b1;
                    n_res.kind   = KIND_EXT;
                    n_res.status = MIDI_NOTE_OFF | {4'b0, r_item.flush_channel};
                    n_res.data1  = w_fl_note[6:0];
                    n_res.last   = w_fl_done;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= n_res_vld;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ROW_W'(1);
            end
        end
    end

    // beat, scan and result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (w_accept) begin
            r_item <= i_item;
            r_row  <= w_row[ROW_W-1:0];
            r_pos  <= w_ent[BIT_W-1:0];
            r_ok   <= w_ok;
        end
        if (r_state == ST_EVAL) begin
            r_play <= w_play;
            r_word <= i_ext_rdata;
            r_idx  <= '0;
            r_cnt  <= '0;
        end else if (r_state == ST_FLUSH) begin
            r_word <= w_fl_clr;
            r_idx  <= r_idx + BIT_W'(1);
            r_cnt  <= r_cnt + CNT_W'(w_fl_bit);
        end
    end

    assign o_res     = r_res;
    assign o_res_vld = r_res_vld;

endmodule
